### sv/gscc_pkg.sv
// ----------------------------------------------------------------------------
// gscc_pkg
// Shared types, codes and constants for the gas sensor channel conditioner.
// ----------------------------------------------------------------------------
package gscc_pkg;

  // operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_SEED   = 2'd1;
  localparam logic [1:0] OP_RECAL  = 2'd2;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_EMA_WEIGHT  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PROC_NOISE  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MEAS_NOISE  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_LOAD_RES    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_BASE_COUNT  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_DETECT_TIME = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_REGEN_TIME  = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_STAGGER     = 3'd7;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [39:0] AIR_RESET = 40'd160000;

  // shared divider widths
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 41;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  channel;
    logic [15:0] sample_sum;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  channel_out;
    logic [31:0] timestamp;
    logic [27:0] raw_average;
    logic [27:0] ema_value;
    logic [27:0] kalman_value;
    logic [39:0] resistance;
    logic [31:0] gas_ratio;
    logic [39:0] air_baseline;
    logic        heater_full;
    logic        chan_locked;
    logic        all_locked;
  } out_item_t;

  typedef enum logic [4:0] {
    ACT_NONE, ACT_LATCH, ACT_RECAL, ACT_SEED, ACT_PHASE,
    ACT_EMA1, ACT_EMA2, ACT_EMA3, ACT_K_ZERO, ACT_K_START, ACT_K_TAKE,
    ACT_GAIN, ACT_EST, ACT_COV, ACT_R_ZERO, ACT_R_START, ACT_R_TAKE,
    ACT_BASE, ACT_B_TAKE, ACT_RATIO_ONE, ACT_RATIO_START, ACT_RATIO_TAKE,
    ACT_EMIT
  } act_t;

  typedef struct packed {
    act_t act;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic op_recal;
    logic op_seed;
    logic op_skip;
    logic den_zero;
    logic res_zero;
    logic lock_now;
    logic base_zero;
    logic out_free;
  } stat_t;

endpackage

### sv/gscc_if.sv
// ----------------------------------------------------------------------------
// gscc_if
// Valid/ready stream interfaces for sample items and readings.
// ----------------------------------------------------------------------------
interface gscc_in_if;
  import gscc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gscc_out_if;
  import gscc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/gscc_divider.sv
// ----------------------------------------------------------------------------
// gscc_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gscc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gscc_pkg::DIV_NW-1:0]   dividend,
  input  logic [gscc_pkg::DIV_DW-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [gscc_pkg::DIV_NW-1:0]   quotient
);
  import gscc_pkg::*;

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [6:0]        count;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem, quotient[DIV_NW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      count    <= 7'(DIV_NW);
      busy     <= 1'b1;
      done     <= 1'b0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_DW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIV_DW-1:0];
      end
      quotient <= {quotient[DIV_NW-2:0], fits};
      count    <= count - 7'd1;
      if (count == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

### sv/gscc_datapath.sv
// ----------------------------------------------------------------------------
// gscc_datapath
// Channel state, configuration, shared multiplier and divider, result register.
// ----------------------------------------------------------------------------
module gscc_datapath #(
  parameter int CHANNELS   = 8,
  parameter int OVERSAMPLE = 16,
  parameter int ADC_BITS   = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gscc_pkg::cmd_t                cmd,
  output gscc_pkg::stat_t               stat,
  input  gscc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gscc_pkg::out_item_t           out_data,
  input  logic                          cfg_write,
  input  logic [gscc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data
);
  import gscc_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [31:0] FULL = 32'(((64'd1 << ADC_BITS) - 64'd1) << 16);

  // averaging by the oversample factor: whole part times sum, plus the
  // leftover part divided by reciprocal multiply (exact for 24-bit operands)
  localparam int unsigned OS_WHOLE = 65536 / OVERSAMPLE;
  localparam int unsigned OS_FRAC  = 65536 % OVERSAMPLE;
  localparam logic [32:0] OS_RECIP =
    33'(((64'd1 << 32) + 64'(OVERSAMPLE) - 64'd1) / 64'(OVERSAMPLE));

  function automatic logic [31:0] sat32(input logic [DIV_NW-1:0] q);
    return (|q[DIV_NW-1:32]) ? '1 : q[31:0];
  endfunction
  function automatic logic [39:0] sat40(input logic [DIV_NW-1:0] q);
    return (|q[DIV_NW-1:40]) ? '1 : q[39:0];
  endfunction

  // configuration
  logic [16:0] ema_weight;
  logic [31:0] process_noise, measurement_noise;
  logic [19:0] load_resistance;
  logic [15:0] baseline_count;
  logic [31:0] detection_time, regeneration_time;
  logic [15:0] stagger_time;

  // latched item
  logic [1:0]  op;
  logic [2:0]  ch;
  logic [15:0] sample_sum;
  logic [31:0] now_ms;

  // per-channel state
  logic [27:0] ema_store [CHANNELS];
  logic [27:0] est_store [CHANNELS];
  logic [31:0] cov_store [CHANNELS];
  logic [55:0] base_sum [CHANNELS];
  logic [15:0] base_seen [CHANNELS];
  logic [39:0] base_val [CHANNELS];
  logic [31:0] phase_start [CHANNELS];
  logic [CHANNELS-1:0] locked;
  logic [CHANNELS-1:0] phase;
  logic recal_mode;

  // working registers
  logic [27:0] raw, m, kal;
  logic [31:0] p, ratio;
  logic [16:0] k;
  logic        dir;
  logic [39:0] r;
  logic [51:0] acc, prod;

  logic [CW-1:0] ci;
  logic [16:0]   w;
  logic [15:0]   cnt;
  logic [32:0]   den, p_sum;
  logic [27:0]   x, diff, v, step;
  logic          dir_c, gate, lock_now, over_det, over_reg, all_lk;
  logic [55:0]   sum_new;
  logic [15:0]   seen_new;
  logic [31:0]   elapsed;
  logic [51:0]   ema_acc, est_rnd, cov_rnd;
  logic [27:0]   x_new;
  logic [19:0]   mul_a;
  logic [31:0]   mul_b;

  logic                div_start, div_busy, div_done;
  logic [DIV_NW-1:0]   div_dd, div_q;
  logic [DIV_DW-1:0]   div_dv;
  logic [27:0]         raw_q;
  logic [32:0]         raw_whole;
  logic [23:0]         raw_rem;
  logic [56:0]         raw_scaled;
  logic [32:0]         raw_full;

  assign ci       = CW'(ch);
  assign w        = (ema_weight > ONE_Q16) ? ONE_Q16 : ema_weight;
  assign cnt      = (baseline_count == 16'd0) ? 16'd1 : baseline_count;
  assign den      = {1'b0, p} + {1'b0, measurement_noise};
  assign p_sum    = {1'b0, cov_store[ci]} + {1'b0, process_noise};
  assign x        = est_store[ci];
  assign dir_c    = m >= x;
  assign diff     = dir_c ? (m - x) : (x - m);
  assign v        = (kal < 28'd65536) ? 28'd65536 : kal;
  assign gate     = !locked[ci] && (!phase[ci] || recal_mode);
  assign sum_new  = base_sum[ci] + {16'd0, r};
  assign seen_new = base_seen[ci] + 16'd1;
  assign lock_now = gate && (seen_new >= cnt);
  assign elapsed  = now_ms - phase_start[ci];
  assign over_det = !elapsed[31] && (elapsed >= detection_time);
  assign over_reg = !elapsed[31] && (elapsed >= regeneration_time);
  assign all_lk   = &locked;
  assign ema_acc  = acc + prod + 52'd32768;
  assign est_rnd  = prod + 52'd32768;
  assign cov_rnd  = prod + 52'd32768;
  assign step     = est_rnd[43:16];
  assign x_new    = dir ? (x + step) : (x - step);

  // raw average = floor(sum * 65536 / OVERSAMPLE), saturated to 28 bits
  assign raw_whole  = 33'(sample_sum) * 33'(OS_WHOLE);
  assign raw_rem    = 24'(sample_sum) * 24'(OS_FRAC);
  assign raw_scaled = 57'(raw_rem) * 57'(OS_RECIP);
  assign raw_full   = raw_whole + 33'(raw_scaled[56:32]);
  assign raw_q      = (|raw_full[32:28]) ? '1 : raw_full[27:0];

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.act)
      ACT_EMA1: begin mul_a = 20'(w);            mul_b = 32'(raw); end
      ACT_EMA2: begin mul_a = 20'(ONE_Q16 - w);  mul_b = 32'(ema_store[ci]); end
      ACT_GAIN: begin mul_a = 20'(k);            mul_b = 32'(diff); end
      ACT_EST:  begin mul_a = 20'(ONE_Q16 - k);  mul_b = p; end
      ACT_COV:  begin mul_a = load_resistance;   mul_b = FULL - {4'd0, v}; end
      default:  begin mul_a = '0;                mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 52'(mul_a) * 52'(mul_b);
  end

  // shared divider operands
  always_comb begin
    div_start = 1'b0;
    div_dd    = '0;
    div_dv    = '0;
    case (cmd.act)
      ACT_K_START: begin
        div_start = 1'b1;
        div_dd    = DIV_NW'({p, 16'd0});
        div_dv    = DIV_DW'(den);
      end
      ACT_R_START: begin
        div_start = 1'b1;
        div_dd    = DIV_NW'({prod, 4'd0});
        div_dv    = DIV_DW'(v);
      end
      ACT_BASE: begin
        div_start = lock_now;
        div_dd    = DIV_NW'(sum_new);
        div_dv    = DIV_DW'(cnt);
      end
      ACT_RATIO_START: begin
        div_start = 1'b1;
        div_dd    = DIV_NW'({r, 16'd0});
        div_dv    = DIV_DW'(base_val[ci]);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  gscc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dd),
    .divisor  (div_dv),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ema_weight        <= 17'd6554;
      process_noise     <= 32'd655;
      measurement_noise <= 32'd65536;
      load_resistance   <= 20'd10000;
      baseline_count    <= 16'd64;
      detection_time    <= 32'd60000;
      regeneration_time <= 32'd30000;
      stagger_time      <= 16'd5000;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EMA_WEIGHT:  ema_weight        <= cfg_data[16:0];
        CFG_PROC_NOISE:  process_noise     <= cfg_data;
        CFG_MEAS_NOISE:  measurement_noise <= cfg_data;
        CFG_LOAD_RES:    load_resistance   <= cfg_data[19:0];
        CFG_BASE_COUNT:  baseline_count    <= cfg_data[15:0];
        CFG_DETECT_TIME: detection_time    <= cfg_data;
        CFG_REGEN_TIME:  regeneration_time <= cfg_data;
        CFG_STAGGER:     stagger_time      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_LATCH: begin
        op         <= in_data.operation;
        ch         <= in_data.channel;
        sample_sum <= in_data.sample_sum;
        now_ms     <= in_data.now_ms;
      end
      ACT_PHASE:      raw <= raw_q;
      ACT_EMA2:       acc <= prod;
      ACT_EMA3: begin
        m <= ema_acc[43:16];
        p <= p_sum[32] ? '1 : p_sum[31:0];
      end
      ACT_K_ZERO:     k   <= '0;
      ACT_K_TAKE:     k   <= div_q[16:0];
      ACT_GAIN:       dir <= dir_c;
      ACT_EST:        kal <= x_new;
      ACT_R_ZERO:     r   <= '0;
      ACT_R_TAKE:     r   <= sat40(div_q);
      ACT_RATIO_ONE:  ratio <= 32'd65536;
      ACT_RATIO_TAKE: ratio <= sat32(div_q);
      default: ;
    endcase
  end

  // channel state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ema_store[i]   <= '0;
        est_store[i]   <= '0;
        cov_store[i]   <= 32'(ONE_Q16);
        base_sum[i]    <= '0;
        base_seen[i]   <= '0;
        base_val[i]    <= AIR_RESET;
        phase_start[i] <= '0;
      end
      locked     <= '0;
      phase      <= '0;
      recal_mode <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.act == ACT_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.act)
        ACT_RECAL: begin
          for (int i = 0; i < CHANNELS; i++) begin
            base_sum[i]  <= '0;
            base_seen[i] <= '0;
          end
          locked     <= '0;
          recal_mode <= 1'b1;
        end
        ACT_SEED: begin
          ema_store[ci]   <= raw_q;
          est_store[ci]   <= raw_q;
          cov_store[ci]   <= 32'(ONE_Q16);
          phase[ci]       <= 1'b0;
          phase_start[ci] <= now_ms + (32'(ch) * 32'(stagger_time));
        end
        ACT_PHASE: begin
          if (!recal_mode) begin
            if (!phase[ci]) begin
              if (over_det) begin
                phase[ci]       <= 1'b1;
                phase_start[ci] <= now_ms;
              end
            end else if (over_reg) begin
              phase[ci]       <= 1'b0;
              phase_start[ci] <= now_ms;
            end
          end
        end
        ACT_EMA3: ema_store[ci] <= ema_acc[43:16];
        ACT_EST:  est_store[ci] <= x_new;
        ACT_COV:  cov_store[ci] <= cov_rnd[47:16];
        ACT_BASE: begin
          if (gate) begin
            base_sum[ci]  <= sum_new;
            base_seen[ci] <= seen_new;
          end
        end
        ACT_B_TAKE: begin
          base_val[ci] <= sat40(div_q);
          locked[ci]   <= 1'b1;
        end
        ACT_RATIO_ONE, ACT_RATIO_START: begin
          if (all_lk) begin
            recal_mode <= 1'b0;
          end
        end
        ACT_EMIT: begin
          out_data.channel_out  <= ch;
          out_data.timestamp    <= now_ms;
          out_data.raw_average  <= raw;
          out_data.ema_value    <= m;
          out_data.kalman_value <= kal;
          out_data.resistance   <= r;
          out_data.gas_ratio    <= ratio;
          out_data.air_baseline <= base_val[ci];
          out_data.heater_full  <= !phase[ci];
          out_data.chan_locked  <= locked[ci];
          out_data.all_locked   <= all_lk;
        end
        default: ;
      endcase
    end
  end

  assign stat.div_busy  = div_busy;
  assign stat.div_done  = div_done;
  assign stat.op_recal  = op == OP_RECAL;
  assign stat.op_seed   = op == OP_SEED;
  assign stat.op_skip   = !(op == OP_SAMPLE || op == OP_SEED || op == OP_RECAL)
                          || (32'(ch) >= 32'(CHANNELS) && op != OP_RECAL);
  assign stat.den_zero  = den == 33'd0;
  assign stat.res_zero  = {4'd0, v} > FULL;
  assign stat.lock_now  = lock_now;
  assign stat.base_zero = base_val[ci] == 40'd0;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

### sv/gscc_controller.sv
// ----------------------------------------------------------------------------
// gscc_controller
// Sequencer stepping one item through the datapath.
// ----------------------------------------------------------------------------
module gscc_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gscc_pkg::stat_t stat,
  output gscc_pkg::cmd_t  cmd
);
  import gscc_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE     = 17'h00001,
    ST_DECODE   = 17'h00002,
    ST_EMA1     = 17'h00004,
    ST_EMA2     = 17'h00008,
    ST_EMA3     = 17'h00010,
    ST_KSTART   = 17'h00020,
    ST_K_WAIT   = 17'h00040,
    ST_GAIN     = 17'h00080,
    ST_EST      = 17'h00100,
    ST_COV      = 17'h00200,
    ST_RSTART   = 17'h00400,
    ST_R_WAIT   = 17'h00800,
    ST_BASE     = 17'h01000,
    ST_B_WAIT   = 17'h02000,
    ST_RATIO    = 17'h04000,
    ST_Q_WAIT   = 17'h08000,
    ST_EMIT     = 17'h10000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    cmd.act    = ACT_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.act    = ACT_LATCH;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.op_recal) begin
          cmd.act    = ACT_RECAL;
          state_next = ST_IDLE;
        end else if (stat.op_skip) begin
          state_next = ST_IDLE;
        end else if (stat.op_seed) begin
          cmd.act    = ACT_SEED;
          state_next = ST_IDLE;
        end else begin
          cmd.act    = ACT_PHASE;
          state_next = ST_EMA1;
        end
      end
      ST_EMA1: begin cmd.act = ACT_EMA1; state_next = ST_EMA2; end
      ST_EMA2: begin cmd.act = ACT_EMA2; state_next = ST_EMA3; end
      ST_EMA3: begin cmd.act = ACT_EMA3; state_next = ST_KSTART; end
      ST_KSTART: begin
        if (stat.den_zero) begin
          cmd.act    = ACT_K_ZERO;
          state_next = ST_GAIN;
        end else begin
          cmd.act    = ACT_K_START;
          state_next = ST_K_WAIT;
        end
      end
      ST_K_WAIT: begin
        if (stat.div_done) begin
          cmd.act    = ACT_K_TAKE;
          state_next = ST_GAIN;
        end
      end
      ST_GAIN: begin cmd.act = ACT_GAIN; state_next = ST_EST; end
      ST_EST:  begin cmd.act = ACT_EST;  state_next = ST_COV; end
      ST_COV:  begin cmd.act = ACT_COV;  state_next = ST_RSTART; end
      ST_RSTART: begin
        if (stat.res_zero) begin
          cmd.act    = ACT_R_ZERO;
          state_next = ST_BASE;
        end else begin
          cmd.act    = ACT_R_START;
          state_next = ST_R_WAIT;
        end
      end
      ST_R_WAIT: begin
        if (stat.div_done) begin
          cmd.act    = ACT_R_TAKE;
          state_next = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.act    = ACT_BASE;
        state_next = stat.lock_now ? ST_B_WAIT : ST_RATIO;
      end
      ST_B_WAIT: begin
        if (stat.div_done) begin
          cmd.act    = ACT_B_TAKE;
          state_next = ST_RATIO;
        end
      end
      ST_RATIO: begin
        if (stat.base_zero) begin
          cmd.act    = ACT_RATIO_ONE;
          state_next = ST_EMIT;
        end else begin
          cmd.act    = ACT_RATIO_START;
          state_next = ST_Q_WAIT;
        end
      end
      ST_Q_WAIT: begin
        if (stat.div_done) begin
          cmd.act    = ACT_RATIO_TAKE;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.act    = ACT_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/gas_sensor_channel_conditioner.sv
// ----------------------------------------------------------------------------
// gas_sensor_channel_conditioner
// Per-channel conditioning for a gas sensor array: heater phase timer,
// averaging, EMA, scalar Kalman filter, divider resistance, baseline lock
// and gas-to-air ratio, in fixed point.
// ----------------------------------------------------------------------------
//
//   port         dir   handshake      payload
//   sample_in    in    valid/ready    operation, channel, sample_sum, now_ms
//   reading_out  out   valid/ready    one reading per sample item
//   cfg_*        in    cfg_write      cfg_index selects, cfg_data
//
// Sequencing: a sample runs through the sequencer steps plus a division on
//   the shared radix-2 divider for the Kalman gain, the resistance, the
//   ratio, and the baseline when it locks; zero gain, zero resistance or
//   zero baseline each skip a division. The average is a constant
//   reciprocal multiply, no division. A seed, a recalibrate or an ignored
//   item is taken and decoded, and the sequencer returns to idle.
// Reset: synchronous; all channel state returns to its power-up values.
// Stalls: a finished reading waits in the output register while the next
//   item is taken; besides its divider waits, the sequencer only holds at
//   its final step if the previous reading has still not been transferred.
// ----------------------------------------------------------------------------
module gas_sensor_channel_conditioner #(
  parameter int CHANNELS   = 8,
  parameter int OVERSAMPLE = 16,
  parameter int ADC_BITS   = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  gscc_in_if.sink                     sample_in,
  gscc_out_if.source                  reading_out,
  input  logic                        cfg_write,
  input  logic [gscc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import gscc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign sample_in.ready = in_ready;

  // sequencer: one item at a time
  gscc_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // channel state, arithmetic and the output register
  gscc_datapath #(
    .CHANNELS   (CHANNELS),
    .OVERSAMPLE (OVERSAMPLE),
    .ADC_BITS   (ADC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (sample_in.data),
    .out_valid (reading_out.valid),
    .out_ready (reading_out.ready),
    .out_data  (reading_out.data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // the sequencer issues no command while a division runs
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> cmd.act == ACT_NONE)
    else $error("command issued while divider busy");

  // a reading is loaded into the output register
  a_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.act == ACT_EMIT |=> reading_out.valid)
    else $error("reading lost at emit");

  // a transfer in starts work, so no second item is taken straight after
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    sample_in.valid && sample_in.ready |=> !sample_in.ready)
    else $error("item taken while busy");

endmodule
